// ===== rtl/core/quad_thrust_allocation_mixer_defines.svh =====
// Assertion macros used by the mixer checker.
// Expects clk and rst to be visible where a macro is used.
`ifndef QUAD_THRUST_ALLOCATION_MIXER_DEFINES_SVH
`define QUAD_THRUST_ALLOCATION_MIXER_DEFINES_SVH

// Check a property on every clock outside reset.
`define QTAM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("qtam check failed");

// Check a property on every clock, reset included.
`define QTAM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("qtam reset check failed");

`endif

// ===== rtl/core/qtam_pkg.sv =====
// Shared constants, word types and flag structs of the thrust mixer.
// No dependencies; the thrust, divider, root, top and checker files import it.
package qtam_pkg;

  localparam int MOTORS          = 4;
  localparam int AXES            = 4;
  localparam int TRIM_BASE       = MOTORS * AXES;
  localparam int LIMIT_BASE      = TRIM_BASE + MOTORS;
  localparam int TABLE_DEPTH     = LIMIT_BASE + MOTORS;
  localparam int COEF_W          = 32;
  localparam int CMD_W           = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAG_W           = 31;
  localparam int QUO_W           = 31;
  localparam int REM_W           = 32;
  localparam int DIV_STEPS       = 31;
  localparam int DIV_PER         = 5;
  localparam int DIV_STAGES      = (DIV_STEPS + DIV_PER - 1) / DIV_PER;
  localparam int ROOT_W          = 16;
  localparam int SQRT_W          = 32;
  localparam int SQRT_STEPS      = 16;
  localparam int SQRT_PER        = 4;
  localparam int SQRT_STAGES     = (SQRT_STEPS + SQRT_PER - 1) / SQRT_PER;
  localparam int THRUST_STAGES   = 5;
  localparam int REG_IDX_W       = 1;

  localparam logic signed [CMD_W-1:0] CMD_RESET_MIN = 16'sh8000;
  localparam logic signed [CMD_W-1:0] CMD_RESET_MAX = 16'sh7FFF;
  localparam logic signed [CMD_W:0]   CMD_POS_LIMIT = 17'sd32767;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } op_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CMD_MIN = 1'b0,
    REG_CMD_MAX = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t                      op;
    logic [4:0]               table_index;
    logic signed [COEF_W-1:0] table_value;
    logic signed [COEF_W-1:0] moment_x;
    logic signed [COEF_W-1:0] moment_y;
    logic signed [COEF_W-1:0] moment_z;
    logic signed [COEF_W-1:0] force_z;
  } in_word_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] command_motor_one;
    logic signed [CMD_W-1:0] command_motor_two;
    logic signed [CMD_W-1:0] command_motor_three;
    logic signed [CMD_W-1:0] command_motor_four;
    logic                    any_clipped;
    logic                    negative_requested;
  } out_word_t;

  // Per-lane status leaving the thrust stages.
  typedef struct packed {
    logic sign;
    logic zero;
    logic clip;
    logic neg;
  } thr_flags_t;

  // Status of one word riding beside the divider and root stages.
  typedef struct packed {
    logic [MOTORS-1:0] sign;
    logic [MOTORS-1:0] zero;
    logic              clip;
    logic              neg;
  } side_t;

endpackage

// ===== rtl/core/qtam_stream_if.sv =====
// Valid/ready stream channel carrying one word of a given type.
// Depends on nothing; the word type comes in as a parameter.
interface qtam_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/qtam_thrust.sv =====
// Thrust lane: products, rounded sum, trim, saturation and limit clamp.
// Five register stages; uses qtam_pkg.
module qtam_thrust #(
  parameter int VALUE_WIDTH = qtam_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [qtam_pkg::COEF_W-1:0] coef [qtam_pkg::AXES],
  input  logic signed [qtam_pkg::COEF_W-1:0] wrench [qtam_pkg::AXES],
  input  logic signed [qtam_pkg::COEF_W-1:0] trim,
  input  logic signed [qtam_pkg::COEF_W-1:0] lim,
  output logic        [qtam_pkg::MAG_W-1:0]  mag,
  output logic        [qtam_pkg::MAG_W-1:0]  den,
  output qtam_pkg::thr_flags_t               flags
);
  import qtam_pkg::*;

  localparam int PROD_W = 2 * COEF_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 3;
  localparam int T0_W   = SUM_W - 16;
  localparam int TF_W   = T0_W + 1;
  localparam int CMP_W  = (VALUE_WIDTH > MAG_W) ? VALUE_WIDTH : MAG_W;
  localparam logic signed [TF_W-1:0] VMAX = (TF_W'(1) <<< (VALUE_WIDTH - 1)) - TF_W'(1);
  localparam logic signed [TF_W-1:0] VMIN = -VMAX - TF_W'(1);

  logic signed [PROD_W-1:0]      prod [AXES];
  logic signed [PAIR_W-1:0]      pair_a, pair_b;
  logic signed [T0_W-1:0]        t0;
  logic signed [VALUE_WIDTH-1:0] t4;
  logic signed [COEF_W-1:0]      trim1, trim2, trim3;
  logic signed [COEF_W-1:0]      lim1, lim2, lim3, lim4;

  logic signed [SUM_W-1:0]       sum_full;
  logic signed [TF_W-1:0]        t_full;
  logic        [VALUE_WIDTH-1:0] abs_t;
  logic        [MAG_W-1:0]       lim_u;
  logic                          lim_bad, over;

  // Exact sum, then one rounding to Q16.16 with ties toward plus infinity.
  assign sum_full = SUM_W'(pair_a) + SUM_W'(pair_b) + SUM_W'(32768);
  assign t_full   = TF_W'(t0) + TF_W'(trim3);

  assign abs_t   = t4[VALUE_WIDTH-1] ? VALUE_WIDTH'(-t4) : VALUE_WIDTH'(t4);
  assign lim_bad = lim4[COEF_W-1] || (lim4 == '0);
  assign lim_u   = lim4[MAG_W-1:0];
  assign over    = CMP_W'(abs_t) > CMP_W'(lim_u);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        prod[a] <= coef[a] * wrench[a];
      end
      trim1 <= trim;
      lim1  <= lim;

      pair_a <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      pair_b <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
      trim2  <= trim1;
      lim2   <= lim1;

      t0    <= sum_full[SUM_W-1:16];
      trim3 <= trim2;
      lim3  <= lim2;

      if (t_full > VMAX) begin
        t4 <= VMAX[VALUE_WIDTH-1:0];
      end else if (t_full < VMIN) begin
        t4 <= VMIN[VALUE_WIDTH-1:0];
      end else begin
        t4 <= t_full[VALUE_WIDTH-1:0];
      end
      lim4 <= lim3;

      // A dead limit forces the command to zero; otherwise clamp magnitude.
      flags.sign <= t4[VALUE_WIDTH-1];
      flags.neg  <= t4[VALUE_WIDTH-1];
      flags.zero <= lim_bad;
      den        <= lim_u;
      if (lim_bad) begin
        flags.clip <= (t4 != '0);
        mag        <= '0;
      end else begin
        flags.clip <= over;
        mag        <= over ? lim_u : MAG_W'(CMP_W'(abs_t));
      end
    end
  end

endmodule

// ===== rtl/core/qtam_div.sv =====
// Pipelined restoring divider: quotient of num * 2^30 / den, num <= den.
// Several quotient bits per stage; uses qtam_pkg.
module qtam_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [qtam_pkg::MAG_W-1:0]   num,
  input  logic [qtam_pkg::MAG_W-1:0]   den,
  output logic [qtam_pkg::QUO_W-1:0]   quo
);
  import qtam_pkg::*;

  logic [REM_W-1:0] rem_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];
  logic [MAG_W-1:0] den_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [REM_W-1:0] rem_in, rem_out;
    logic [QUO_W-1:0] quo_in, quo_out;
    logic [MAG_W-1:0] den_in;

    if (s == 0) begin : g_first
      assign rem_in = REM_W'(num);
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end

    always_comb begin
      int j;
      rem_out = rem_in;
      quo_out = quo_in;
      for (int k = 0; k < DIV_PER; k++) begin
        j = s * DIV_PER + k;
        if (j < DIV_STEPS) begin
          if (j != 0) begin
            rem_out = rem_out << 1;
          end
          if (rem_out >= REM_W'(den_in)) begin
            rem_out = rem_out - REM_W'(den_in);
            quo_out = {quo_out[QUO_W-2:0], 1'b1};
          end else begin
            quo_out = {quo_out[QUO_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= rem_out;
        quo_q[s] <= quo_out;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo = quo_q[DIV_STAGES-1];

endmodule

// ===== rtl/core/qtam_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one result bit per step.
// Several steps per stage; uses qtam_pkg.
module qtam_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [qtam_pkg::QUO_W-1:0]  rad,
  output logic [qtam_pkg::ROOT_W-1:0] root
);
  import qtam_pkg::*;

  logic [SQRT_W-1:0] x_q [SQRT_STAGES];
  logic [SQRT_W-1:0] r_q [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [SQRT_W-1:0] x_in, r_in, x_out, r_out;

    if (s == 0) begin : g_first
      assign x_in = SQRT_W'(rad);
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_q[s-1];
      assign r_in = r_q[s-1];
    end

    always_comb begin
      int j;
      logic [SQRT_W-1:0] bitv;
      x_out = x_in;
      r_out = r_in;
      for (int k = 0; k < SQRT_PER; k++) begin
        j = s * SQRT_PER + k;
        if (j < SQRT_STEPS) begin
          bitv = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - j));
          if (x_out >= r_out + bitv) begin
            x_out = x_out - (r_out + bitv);
            r_out = (r_out >> 1) + bitv;
          end else begin
            r_out = r_out >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_q[s] <= x_out;
        r_q[s] <= r_out;
      end
    end
  end

  assign root = r_q[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

// ===== rtl/core/quad_thrust_allocation_mixer.sv =====
// Quad thrust allocation mixer, top level.
// Uses qtam_pkg, qtam_stream_if, qtam_thrust, qtam_div and qtam_sqrt.
//
// in_ch takes words of two kinds. A load word (op = load) writes one
// coefficient table entry: mixing rows at 0-15, trims at 16-19, thrust
// limits at 20-23; indexes above 23 are dropped. An allocate word carries
// the wrench and yields exactly one out_ch word: four Q1.15 motor commands
// plus the clipped and negative-thrust flags. Load words yield nothing.
// The table must be loaded before allocating; cfg_we/cfg_index/cfg_data set
// the command clamp range; the user must write them only while the block
// is idle, which the block itself does not enforce.
// Every stage advances together, one word per cycle unless a finished
// word waits behind a held output: 5 thrust stages (products, pair sums,
// rounding, trim and saturation, limit clamp), 7 divider stages and 4
// square-root stages, then the output register. Throughput is one word
// per cycle when out_ch never stalls. Loads take effect at the accept
// edge, so an allocate accepted in the next cycle sees the new entry.
// When out_ch stalls, bubbles ahead of the output keep draining and in_ch
// stays ready until a finished word sits behind the held output.
// Reset clears valids and sets the full clamp range; table contents stay undefined.
module quad_thrust_allocation_mixer #(
  parameter int VALUE_WIDTH = qtam_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [qtam_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [qtam_pkg::CMD_W-1:0]        cfg_data,
  qtam_stream_if.sink                       in_ch,
  qtam_stream_if.source                     out_ch
);
  import qtam_pkg::*;

  localparam int SIDE_LEN = DIV_STAGES + SQRT_STAGES;
  localparam int LAT      = THRUST_STAGES + SIDE_LEN;

  // Coefficient table; never cleared, each entry read at a fixed lane.
  logic signed [COEF_W-1:0] coef_tab [TABLE_DEPTH];

  logic signed [CMD_W-1:0] cmd_min, cmd_max;
  logic [LAT-1:0]          vld;
  side_t                   side_q [SIDE_LEN];
  side_t                   side_in;
  logic                    en, load_fire, alloc_fire;

  logic signed [COEF_W-1:0] wrench [AXES];
  logic [MAG_W-1:0]         mag    [MOTORS];
  logic [MAG_W-1:0]         den    [MOTORS];
  logic [QUO_W-1:0]         quo    [MOTORS];
  logic [ROOT_W-1:0]        root   [MOTORS];
  thr_flags_t               flags  [MOTORS];
  logic signed [CMD_W-1:0]  cmd    [MOTORS];

  // Advance unless a finished word would run into a held output.
  assign en          = !vld[LAT-1] || !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign load_fire   = in_ch.valid && en && (in_ch.data.op == OP_LOAD);
  assign alloc_fire  = in_ch.valid && en && (in_ch.data.op == OP_ALLOC);

  assign wrench[0] = in_ch.data.moment_x;
  assign wrench[1] = in_ch.data.moment_y;
  assign wrench[2] = in_ch.data.moment_z;
  assign wrench[3] = in_ch.data.force_z;

  always_ff @(posedge clk) begin
    if (load_fire && (in_ch.data.table_index < 5'(TABLE_DEPTH))) begin
      coef_tab[in_ch.data.table_index] <= in_ch.data.table_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_min <= CMD_RESET_MIN;
      cmd_max <= CMD_RESET_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CMD_MIN: cmd_min <= cfg_data;
        REG_CMD_MAX: cmd_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // One lane per motor: thrust, normalizing divide, square root.
  for (genvar m = 0; m < MOTORS; m++) begin : g_lane
    logic signed [COEF_W-1:0] row [AXES];

    for (genvar a = 0; a < AXES; a++) begin : g_row
      assign row[a] = coef_tab[m * AXES + a];
    end

    qtam_thrust #(.VALUE_WIDTH(VALUE_WIDTH)) u_thrust (
      .clk    (clk),
      .en     (en),
      .coef   (row),
      .wrench (wrench),
      .trim   (coef_tab[TRIM_BASE + m]),
      .lim    (coef_tab[LIMIT_BASE + m]),
      .mag    (mag[m]),
      .den    (den[m]),
      .flags  (flags[m])
    );

    qtam_div u_div (
      .clk (clk),
      .en  (en),
      .num (mag[m]),
      .den (den[m]),
      .quo (quo[m])
    );

    qtam_sqrt u_sqrt (
      .clk  (clk),
      .en   (en),
      .rad  (quo[m]),
      .root (root[m])
    );
  end

  // Collapse lane flags into the word's status as it leaves the thrust stages.
  always_comb begin
    side_in = '0;
    for (int m = 0; m < MOTORS; m++) begin
      side_in.sign[m] = flags[m].sign;
      side_in.zero[m] = flags[m].zero;
      side_in.clip    = side_in.clip | flags[m].clip;
      side_in.neg     = side_in.neg | flags[m].neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int i = 1; i < SIDE_LEN; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], alloc_fire};
    end
  end

  // Zero dead lanes, sign the rest, cap the positive end, then clamp in order.
  always_comb begin
    logic signed [CMD_W:0] lo, hi, c;
    lo = CMD_W'(0) + {cmd_min[CMD_W-1], cmd_min};
    hi = {cmd_max[CMD_W-1], cmd_max};
    if (lo > hi) begin
      lo = {cmd_max[CMD_W-1], cmd_max};
      hi = {cmd_min[CMD_W-1], cmd_min};
    end
    for (int m = 0; m < MOTORS; m++) begin
      if (side_q[SIDE_LEN-1].zero[m]) begin
        c = '0;
      end else if (side_q[SIDE_LEN-1].sign[m]) begin
        c = -$signed({1'b0, root[m]});
      end else begin
        c = $signed({1'b0, root[m]});
        if (c > CMD_POS_LIMIT) begin
          c = CMD_POS_LIMIT;
        end
      end
      if (c < lo) begin
        c = lo;
      end
      if (c > hi) begin
        c = hi;
      end
      cmd[m] = c[CMD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en && vld[LAT-1]) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[LAT-1]) begin
      out_ch.data.command_motor_one   <= cmd[0];
      out_ch.data.command_motor_two   <= cmd[1];
      out_ch.data.command_motor_three <= cmd[2];
      out_ch.data.command_motor_four  <= cmd[3];
      out_ch.data.any_clipped         <= side_q[SIDE_LEN-1].clip;
      out_ch.data.negative_requested  <= side_q[SIDE_LEN-1].neg;
    end
  end

endmodule

// ===== rtl/core/qtam_checker.sv =====
// Port-level checks of the mixer, bound to the top level.
// Uses qtam_pkg and the macros in quad_thrust_allocation_mixer_defines.svh.
`include "quad_thrust_allocation_mixer_defines.svh"

module qtam_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input qtam_pkg::out_word_t out_data
);
  import qtam_pkg::*;

  `QTAM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `QTAM_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_data))
  `QTAM_ASSERT(a_ready_when_empty, !out_valid |-> in_ready)
  `QTAM_ASSERT_RST(a_reset_clears, rst |=> !out_valid)

endmodule

bind quad_thrust_allocation_mixer qtam_checker u_qtam_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
